/* rtl/mfpt_pkg.sv */
// Shared types and constants for the Manhattan farthest-point tracker.
// No dependencies; every other file in rtl/ takes names from here by scope.
package mfpt_pkg;

    // Fixed field widths.
    localparam int COORD_BITS   = 16;
    localparam int DIST_BITS    = 18;
    localparam int DIMS_BITS    = 3;
    localparam int MAX_DIMS_DEF = 4;
    localparam int APB_DATA     = 32;
    localparam int APB_ADDR     = 3;

    // Register reset value and register indexes.
    localparam logic [DIMS_BITS-1:0] ACTIVE_DIMS_RST = 3'd2;
    localparam logic                 REG_ACTIVE_DIMS = 1'b0;

    // Operation codes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Input word: one operation and one point.
    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] coord_0;
        logic signed [COORD_BITS-1:0] coord_1;
        logic signed [COORD_BITS-1:0] coord_2;
        logic signed [COORD_BITS-1:0] coord_3;
    } point_word_t;

    // Result word returned for each query.
    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 no_points;
    } result_word_t;

    // Control handed from the top level to every lane.
    typedef struct packed {
        logic add_en;
        logic query_en;
        logic has_points;
    } lane_ctrl_t;

endpackage

/* rtl/manhattan_farthest_point_tracker.sv */
// Top level of the Manhattan farthest-point tracker: APB register, lane
// array and merging stage. Depends on mfpt_pkg, mfpt_lane and mfpt_merge.
//
//  Channel   Handshake              Payload              Direction
//  --------  ---------------------  -------------------  ---------
//  input     start, busy            item (point word)    in
//  result    done (one-cycle pulse) result (result word) out
//  config    psel/penable/pwrite    paddr, pwdata/prdata in/out
//
// One word is taken every clock cycle; busy stays low.
// A query's result appears on done after passing the lane registers and
// then the merge register.
// An add followed at once by a query sees the add, as the lane extremes
// update at the accepting edge. Adds produce no result.
// Reset clears the point flag, the dimension register (to 2) and done.
// The receiver cannot stall: each result is valid for exactly one cycle.
module manhattan_farthest_point_tracker #(
    parameter int MAX_DIMS = mfpt_pkg::MAX_DIMS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mfpt_pkg::point_word_t               item,
    output mfpt_pkg::result_word_t              result,
    output logic                                done,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfpt_pkg::APB_ADDR-1:0]       paddr,
    input  logic [mfpt_pkg::APB_DATA-1:0]       pwdata,
    output logic [mfpt_pkg::APB_DATA-1:0]       prdata,
    output logic                                pready
);

    localparam int NUM_SUMS = 1 << (MAX_DIMS - 1);
    localparam int SUM_BITS = mfpt_pkg::COORD_BITS + $clog2(MAX_DIMS) + 1;
    localparam int CB       = mfpt_pkg::COORD_BITS;
    localparam int DB       = mfpt_pkg::DIMS_BITS;

    logic [DB-1:0]                      active_dims_reg;
    logic [DB-1:0]                      dims_eff;
    logic                               has_points_reg;
    logic                               query_reg;
    logic                               empty_reg;
    logic                               accept;
    logic                               cfg_wr;
    logic [CB-1:0]                      coord_raw [4];
    logic [MAX_DIMS-1:0][CB-1:0]        coord_use;
    logic [NUM_SUMS-1:0][SUM_BITS-1:0]  lane_diff;
    mfpt_pkg::lane_ctrl_t               ctrl;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start & ~busy;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Register file: one register, active_dims.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg <= mfpt_pkg::ACTIVE_DIMS_RST;
        end
        else if (cfg_wr && paddr[2] == mfpt_pkg::REG_ACTIVE_DIMS)
        begin
            active_dims_reg <= pwdata[DB-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == mfpt_pkg::REG_ACTIVE_DIMS)
        begin
            prdata = mfpt_pkg::APB_DATA'(active_dims_reg);
        end
    end

    // Clamp the dimension count to the range the array supports.
    always_comb
    begin
        if (active_dims_reg == '0)
        begin
            dims_eff = DB'(1);
        end
        else if (active_dims_reg > DB'(MAX_DIMS))
        begin
            dims_eff = DB'(MAX_DIMS);
        end
        else
        begin
            dims_eff = active_dims_reg;
        end
    end

    // Coordinates beyond the active count are taken as zero.
    assign coord_raw[0] = item.coord_0;
    assign coord_raw[1] = item.coord_1;
    assign coord_raw[2] = item.coord_2;
    assign coord_raw[3] = item.coord_3;

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            coord_use[k] = (DB'(k) < dims_eff) ? coord_raw[k] : '0;
        end
    end

    // Lane control for the word being taken this cycle.
    always_comb
    begin
        ctrl.add_en     = accept && (item.op == mfpt_pkg::OP_ADD);
        ctrl.query_en   = accept && (item.op == mfpt_pkg::OP_QUERY);
        ctrl.has_points = has_points_reg;
    end

    // Point flag, and the query marker that travels beside the lane results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_points_reg <= 1'b0;
            query_reg      <= 1'b0;
            empty_reg      <= 1'b0;
        end
        else
        begin
            query_reg <= ctrl.query_en;
            empty_reg <= ~has_points_reg;
            if (ctrl.add_en)
            begin
                has_points_reg <= 1'b1;
            end
        end
    end

    // One lane for each sign combination.
    for (genvar g = 0; g < NUM_SUMS; g++)
    begin : g_lane
        mfpt_lane #(
            .MAX_DIMS (MAX_DIMS),
            .LANE_IDX (g),
            .SUM_BITS (SUM_BITS)
        ) u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .coords (coord_use),
            .diff   (lane_diff[g])
        );
    end

    mfpt_merge #(
        .NUM_SUMS (NUM_SUMS),
        .SUM_BITS (SUM_BITS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_reg),
        .empty       (empty_reg),
        .lane_diff   (lane_diff),
        .result      (result),
        .done        (done)
    );

endmodule

/* rtl/mfpt_lane.sv */
// One sign-combination lane: forms its signed coordinate sum, keeps its running
// extremes and registers its largest distance for a query. Uses mfpt_pkg.
module mfpt_lane #(
    parameter int MAX_DIMS = mfpt_pkg::MAX_DIMS_DEF,
    parameter int LANE_IDX = 0,
    parameter int SUM_BITS = mfpt_pkg::COORD_BITS + 3
) (
    input  logic                                           clk,
    input  mfpt_pkg::lane_ctrl_t                           ctrl,
    input  logic [MAX_DIMS-1:0][mfpt_pkg::COORD_BITS-1:0]  coords,
    output logic [SUM_BITS-1:0]                            diff
);

    logic signed [SUM_BITS-1:0] max_reg;
    logic signed [SUM_BITS-1:0] min_reg;
    logic        [SUM_BITS-1:0] diff_reg;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS:0]   d_max;
    logic signed [SUM_BITS:0]   d_min;
    logic        [SUM_BITS:0]   m_max;
    logic        [SUM_BITS:0]   m_min;
    logic        [SUM_BITS-1:0] diff_next;

    // Signed sum: coordinate k is subtracted when its bit of the lane index is set.
    always_comb
    begin
        logic signed [SUM_BITS-1:0] term;
        sum  = '0;
        term = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            term = SUM_BITS'(signed'(coords[k]));
            if (((LANE_IDX >> (MAX_DIMS - 1 - k)) & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
    end

    // Distance from the query sum to both extremes; keep the larger.
    always_comb
    begin
        d_max = (SUM_BITS+1)'(max_reg) - (SUM_BITS+1)'(sum);
        d_min = (SUM_BITS+1)'(min_reg) - (SUM_BITS+1)'(sum);
        m_max = (d_max < 0) ? (SUM_BITS+1)'(-d_max) : (SUM_BITS+1)'(d_max);
        m_min = (d_min < 0) ? (SUM_BITS+1)'(-d_min) : (SUM_BITS+1)'(d_min);
        diff_next = (m_max > m_min) ? m_max[SUM_BITS-1:0] : m_min[SUM_BITS-1:0];
    end

    // The first add loads both extremes; later adds widen them.
    always_ff @(posedge clk)
    begin
        if (ctrl.add_en)
        begin
            if (!ctrl.has_points || sum > max_reg)
            begin
                max_reg <= sum;
            end
            if (!ctrl.has_points || sum < min_reg)
            begin
                min_reg <= sum;
            end
        end
        if (ctrl.query_en)
        begin
            diff_reg <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

/* rtl/mfpt_merge.sv */
// Merging stage: takes the largest lane distance, saturates it to the
// result field and registers the result word. Uses mfpt_pkg.
module mfpt_merge #(
    parameter int NUM_SUMS = 8,
    parameter int SUM_BITS = mfpt_pkg::COORD_BITS + 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               query_valid,
    input  logic                               empty,
    input  logic [NUM_SUMS-1:0][SUM_BITS-1:0]  lane_diff,
    output mfpt_pkg::result_word_t             result,
    output logic                               done
);

    localparam int WIDE = (SUM_BITS > mfpt_pkg::DIST_BITS) ? SUM_BITS : mfpt_pkg::DIST_BITS;

    logic [SUM_BITS-1:0]          best;
    logic [WIDE-1:0]              best_wide;
    mfpt_pkg::result_word_t       result_reg;
    mfpt_pkg::result_word_t       result_next;
    logic                         done_reg;

    // Largest of the lane distances.
    always_comb
    begin
        best = '0;
        for (int i = 0; i < NUM_SUMS; i++)
        begin
            if (lane_diff[i] > best)
            begin
                best = lane_diff[i];
            end
        end
    end

    // Saturate to the distance field; an empty set answers zero.
    always_comb
    begin
        best_wide = WIDE'(best);
        result_next.no_points = empty;
        if (empty)
        begin
            result_next.distance = '0;
        end
        else if (best_wide > WIDE'({mfpt_pkg::DIST_BITS{1'b1}}))
        begin
            result_next.distance = '1;
        end
        else
        begin
            result_next.distance = best_wide[mfpt_pkg::DIST_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_valid)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= query_valid;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for manhattan_farthest_point_tracker: directed and random
// add/query words, active_dims register writes over the APB port, and a scoreboard.
// Depends on mfpt_pkg and the tracker RTL only.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SUMS = 1 << (mfpt_pkg::MAX_DIMS_DEF - 1);
    localparam int EXT_BITS = mfpt_pkg::DIST_BITS + 1;

    // Keeps its own copy of the register and the per-sum extremes, predicts the
    // result of each accepted query word and checks the results in order.
    class farthest_distance_board;
        logic [mfpt_pkg::DIMS_BITS-1:0] dims_reg;
        logic signed [EXT_BITS-1:0]     sum_max [NUM_SUMS];
        logic signed [EXT_BITS-1:0]     sum_min [NUM_SUMS];
        bit                             seen_point;
        mfpt_pkg::result_word_t         awaited [$];
        int unsigned                    mismatches;

        function new();
            dims_reg   = mfpt_pkg::ACTIVE_DIMS_RST;
            seen_point = 1'b0;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: %s", $time, msg);
        endfunction

        function void set_dims(logic [mfpt_pkg::DIMS_BITS-1:0] value);
            dims_reg = value;
        endfunction

        // Updates the extremes for an add, or queues the expected result of a query.
        function void note_word(mfpt_pkg::point_word_t w);
            logic signed [EXT_BITS-1:0] pt [mfpt_pkg::MAX_DIMS_DEF];
            logic signed [EXT_BITS-1:0] lane_sum;
            logic signed [EXT_BITS:0]   gap;
            logic signed [EXT_BITS:0]   best;
            int                         used;
            mfpt_pkg::result_word_t     want;
            used = (dims_reg < 1) ? 1 :
                   (dims_reg > mfpt_pkg::MAX_DIMS_DEF) ? mfpt_pkg::MAX_DIMS_DEF :
                   int'(dims_reg);
            pt[0] = w.coord_0;
            pt[1] = w.coord_1;
            pt[2] = w.coord_2;
            pt[3] = w.coord_3;
            for (int k = used; k < mfpt_pkg::MAX_DIMS_DEF; k++)
                pt[k] = '0;
            best = '0;
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                lane_sum = pt[0];
                for (int k = 1; k < mfpt_pkg::MAX_DIMS_DEF; k++)
                begin
                    if (((i >> (mfpt_pkg::MAX_DIMS_DEF - 1 - k)) & 1) != 0)
                        lane_sum = lane_sum - pt[k];
                    else
                        lane_sum = lane_sum + pt[k];
                end
                if (w.op == mfpt_pkg::OP_ADD)
                begin
                    if (!seen_point || lane_sum > sum_max[i])
                        sum_max[i] = lane_sum;
                    if (!seen_point || lane_sum < sum_min[i])
                        sum_min[i] = lane_sum;
                end
                else if (seen_point)
                begin
                    gap = sum_max[i] - lane_sum;
                    if (gap < 0)
                        gap = -gap;
                    if (gap > best)
                        best = gap;
                    gap = sum_min[i] - lane_sum;
                    if (gap < 0)
                        gap = -gap;
                    if (gap > best)
                        best = gap;
                end
            end
            if (w.op == mfpt_pkg::OP_ADD)
            begin
                seen_point = 1'b1;
                return;
            end
            // An empty set answers zero with the no-points flag; otherwise saturate.
            if (best > (2 ** mfpt_pkg::DIST_BITS) - 1)
                best = (2 ** mfpt_pkg::DIST_BITS) - 1;
            want.distance  = seen_point ? best[mfpt_pkg::DIST_BITS-1:0] : '0;
            want.no_points = !seen_point;
            awaited.push_back(want);
        endfunction

        function void check_result(mfpt_pkg::result_word_t got);
            mfpt_pkg::result_word_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("unexpected result distance %0d no_points %0b",
                               got.distance, got.no_points));
                return;
            end
            want = awaited.pop_front();
            if (got.distance !== want.distance || got.no_points !== want.no_points)
                flag($sformatf(
                    "distance expected %0d got %0d, no_points expected %0b got %0b",
                    want.distance, got.distance, want.no_points, got.no_points));
        endfunction

        function int unsigned faults();
            if (awaited.size() != 0)
                $display("%0d expected results never arrived", awaited.size());
            return mismatches + awaited.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    mfpt_pkg::point_word_t         item;
    mfpt_pkg::result_word_t        result;
    logic                          done;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mfpt_pkg::APB_ADDR-1:0] paddr;
    logic [mfpt_pkg::APB_DATA-1:0] pwdata;
    logic [mfpt_pkg::APB_DATA-1:0] prdata;
    logic                          pready;

    farthest_distance_board board = new();

    manhattan_farthest_point_tracker i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .result  (result),
        .done    (done),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Watch both handshakes; values seen here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_word(item);
            if (done)
                board.check_result(result);
        end
    end

    function automatic mfpt_pkg::point_word_t make_word(logic op, int c0, int c1,
                                                        int c2, int c3);
        mfpt_pkg::point_word_t w;
        w.op      = op;
        w.coord_0 = mfpt_pkg::COORD_BITS'(c0);
        w.coord_1 = mfpt_pkg::COORD_BITS'(c1);
        w.coord_2 = mfpt_pkg::COORD_BITS'(c2);
        w.coord_3 = mfpt_pkg::COORD_BITS'(c3);
        return w;
    endfunction

    // A coordinate within +/- 2^(span-1); with wide set, often a field extreme.
    function automatic logic signed [mfpt_pkg::COORD_BITS-1:0] rand_coord(int span, bit wide);
        int pick;
        pick = $urandom_range(0, 19);
        if (wide && pick == 0)
            return {1'b1, {(mfpt_pkg::COORD_BITS-1){1'b0}}};
        if (wide && pick == 1)
            return {1'b0, {(mfpt_pkg::COORD_BITS-1){1'b1}}};
        if (span >= mfpt_pkg::COORD_BITS)
            return mfpt_pkg::COORD_BITS'($urandom);
        return mfpt_pkg::COORD_BITS'($urandom_range(0, (1 << span) - 1) - (1 << (span - 1)));
    endfunction

    // Offers one word, after an idle gap with the given chance; returns at acceptance
    // with start still high so that back-to-back words follow without a bubble.
    task automatic send_word(mfpt_pkg::point_word_t w, int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stops offering words and waits until every expected result has come.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes active_dims with random upper data bits, then reads it back.
    task automatic write_dims(logic [mfpt_pkg::DIMS_BITS-1:0] value);
        logic [mfpt_pkg::APB_DATA-1:0] data;
        data = $urandom;
        data[mfpt_pkg::DIMS_BITS-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mfpt_pkg::APB_ADDR'(4 * mfpt_pkg::REG_ACTIVE_DIMS);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_dims(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[mfpt_pkg::DIMS_BITS-1:0] !== value)
            board.flag($sformatf("active_dims read %0d, written %0d",
                                 prdata[mfpt_pkg::DIMS_BITS-1:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int                    phase_dims [8] = '{1, 3, 4, 5, 2, 6, 0, 4};
        int                    phase_idle [8] = '{0, 52, 0, 14, 52, 0, 14, 0};
        int                    span;
        bit                    last;
        mfpt_pkg::point_word_t w;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Queries on the empty set, then adds with queries straight behind them.
        // Coordinates beyond two dimensions carry extremes that must be ignored.
        send_word(make_word(mfpt_pkg::OP_QUERY, 0, 0, 0, 0), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, -32768, 32767, -32768, 32767), 0);
        send_word(make_word(mfpt_pkg::OP_ADD, 5, -7, -32768, 32767), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, -32768, -32768, 32767, -32768), 0);
        send_word(make_word(mfpt_pkg::OP_ADD, -30, 12, 32767, -32768), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, 32767, 32767, 32767, 32767), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, 0, 0, 0, 0), 0);
        settle();

        // Four dimensions: extremes stored under two dimensions stay as they were.
        write_dims(3'd4);
        send_word(make_word(mfpt_pkg::OP_QUERY, 32767, -32768, 32767, -32768), 0);
        send_word(make_word(mfpt_pkg::OP_ADD, 1, 2, 3, 4), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, -1, -2, -3, -4), 0);
        settle();

        // A dimension count of zero behaves as one.
        write_dims(3'd0);
        send_word(make_word(mfpt_pkg::OP_ADD, 50, 32767, -32768, 32767), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, -32768, 0, 0, 0), 0);
        settle();

        // A dimension count above the maximum behaves as four.
        write_dims(3'd7);
        send_word(make_word(mfpt_pkg::OP_ADD, -10, -20, 30, -40), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, 32767, 32767, -32768, 32767), 0);
        send_word(make_word(mfpt_pkg::OP_QUERY, -32768, -32768, -32768, -32768), 0);
        settle();

        // Random phases; the spread of added points grows so the extremes keep moving.
        for (int p = 0; p < 8; p++)
        begin
            write_dims(phase_dims[p][mfpt_pkg::DIMS_BITS-1:0]);
            last = (p == 7);
            span = last ? mfpt_pkg::COORD_BITS : 8 + p;
            for (int n = 0; n < 70; n++)
            begin
                w.op = ($urandom_range(0, 99) < 55) ? mfpt_pkg::OP_ADD : mfpt_pkg::OP_QUERY;
                if (w.op == mfpt_pkg::OP_QUERY && $urandom_range(0, 1) == 1)
                begin
                    w.coord_0 = rand_coord(mfpt_pkg::COORD_BITS, 1'b1);
                    w.coord_1 = rand_coord(mfpt_pkg::COORD_BITS, 1'b1);
                    w.coord_2 = rand_coord(mfpt_pkg::COORD_BITS, 1'b1);
                    w.coord_3 = rand_coord(mfpt_pkg::COORD_BITS, 1'b1);
                end
                else
                begin
                    w.coord_0 = rand_coord(span, last);
                    w.coord_1 = rand_coord(span, last);
                    w.coord_2 = rand_coord(span, last);
                    w.coord_3 = rand_coord(span, last);
                end
                send_word(w, phase_idle[p]);
            end
            settle();
        end

        if (board.faults() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
